// ===== src/pta_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the peer table with aging.
// No dependencies; imported by pta_store and peer_table_with_aging.
package pta_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 4;

    localparam logic [TIME_W-1:0] DEAD_TIME_RST = 32'd60;

    typedef enum logic [1:0] {
        FUNC_FIND_MAC = 2'd0,
        FUNC_FIND_IP  = 2'd1,
        FUNC_ADD      = 2'd2,
        FUNC_SWEEP    = 2'd3
    } func_t;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] seen;
    } entry_t;

    // Control from the sequencer to the entry store
    typedef struct packed {
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_entry;
        logic             clr_en;
        logic [IDX_W-1:0] clr_idx;
    } store_ctl_t;

endpackage

// ===== src/pta_store.sv =====
`timescale 1ns / 1ps
// Entry store: MAC/IP/last-seen memory with registered read, plus valid bits.
// Depends on pta_pkg.
module pta_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  pta_pkg::store_ctl_t ctl,
    output pta_pkg::entry_t     rd_entry,
    output logic                rd_valid
);
    import pta_pkg::*;

    entry_t             table_mem [ENTRIES];
    entry_t             rd_entry_reg;
    logic               rd_valid_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            table_mem[ctl.wr_idx] <= ctl.wr_entry;
        end
        rd_entry_reg <= table_mem[ctl.rd_idx];
    end

    // a write always leaves its entry live; aging clears and writes never fall in the same cycle
    always_comb begin
        valid_next = valid_reg;
        if (ctl.clr_en) begin
            valid_next[ctl.clr_idx] = 1'b0;
        end
        if (ctl.wr_en) begin
            valid_next[ctl.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[ctl.rd_idx];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== src/peer_table_with_aging.sv =====
`timescale 1ns / 1ps
// Peer table with aging: find by MAC or IP, sweep, add/refresh with eviction.
// Depends on pta_pkg and pta_store.
//
//  channel  ports                                        direction  role
//  s_       s_valid/s_ready, func, mac, ip, now          in         request
//  m_       m_valid/m_ready, hit, slot, mac/ip/seen, ev  out        result
//  cfg_     cfg_valid/cfg_ready, cfg_data                in         dead_time write
//
// An add takes the idle accept cycle, a scan of every entry through the single read
// port of the entry memory (one entry per cycle, one shared age subtract/compare),
// a write cycle, then the result load. Finds and sweeps skip the write. s_ready is
// high only while idle. The result sits in an output register; a stalled m_ready
// holds the next result in the response state. aresetn (synchronous) clears all
// valid bits and sets dead_time to 60.
module peer_table_with_aging (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_func,
    input  logic [pta_pkg::MAC_W-1:0]     s_mac_addr,
    input  logic [pta_pkg::IP_W-1:0]      s_ip_addr,
    input  logic [pta_pkg::TIME_W-1:0]    s_now_sec,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [pta_pkg::SLOT_W-1:0]    m_slot,
    output logic [pta_pkg::MAC_W-1:0]     m_mac_out,
    output logic [pta_pkg::IP_W-1:0]      m_ip_out,
    output logic [pta_pkg::TIME_W-1:0]    m_seen_out,
    output logic                          m_evicted,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pta_pkg::TIME_W-1:0]    cfg_data
);
    import pta_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               eval_reg;
    logic [IDX_W-1:0]   eidx_reg;
    func_t              func_reg;
    logic [MAC_W-1:0]   key_mac_reg;
    logic [IP_W-1:0]    key_ip_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  dead_time_reg;

    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    entry_t             found_ent_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [TIME_W-1:0]  best_age_reg;
    logic [IDX_W-1:0]   best_idx_reg;

    logic               m_valid_reg;
    logic               m_hit_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    logic [MAC_W-1:0]   m_mac_reg;
    logic [IP_W-1:0]    m_ip_reg;
    logic [TIME_W-1:0]  m_seen_reg;
    logic               m_evicted_reg;

    store_ctl_t         ctl;
    entry_t             rd_entry;
    logic               rd_valid;

    // shared age unit and per-entry decisions
    logic [TIME_W-1:0]  age;
    logic               aging;
    logic               dead;
    logic               alive;
    logic               key_hit;
    logic               match;
    logic               last_cycle;
    logic [IDX_W-1:0]   pick_idx;
    entry_t             new_entry;
    logic               out_free;

    pta_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    assign age     = now_reg - rd_entry.seen;
    assign aging   = (func_reg == FUNC_ADD) || (func_reg == FUNC_SWEEP);
    assign dead    = eval_reg && rd_valid && aging && (age >= dead_time_reg);
    assign alive   = rd_valid && !dead;
    assign key_hit = (func_reg == FUNC_FIND_IP) ? (rd_entry.ip == key_ip_reg)
                                                : (rd_entry.mac == key_mac_reg);
    assign match   = eval_reg && alive && key_hit && (func_reg != FUNC_SWEEP);

    assign last_cycle = (cnt_reg == CNT_W'(ENTRIES));
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        priority if (found_reg) begin
            pick_idx = found_idx_reg;
        end else if (free_reg) begin
            pick_idx = free_idx_reg;
        end else begin
            pick_idx = best_idx_reg;
        end
    end

    assign new_entry = '{mac: key_mac_reg, ip: key_ip_reg, seen: now_reg};

    always_comb begin
        ctl.rd_idx   = cnt_reg[IDX_W-1:0];
        ctl.wr_en    = (state_reg == ST_WRITE);
        ctl.wr_idx   = pick_idx;
        ctl.wr_entry = new_entry;
        ctl.clr_en   = dead;
        ctl.clr_idx  = eidx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            eval_reg      <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            dead_time_reg <= DEAD_TIME_RST;
        end else begin
            if (cfg_valid) begin
                dead_time_reg <= cfg_data;
            end

            // the response state loads the output register itself
            if (m_valid_reg && m_ready && (state_reg != ST_RESP)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        func_reg    <= func_t'(s_func);
                        key_mac_reg <= s_mac_addr;
                        key_ip_reg  <= s_ip_addr;
                        now_reg     <= s_now_sec;
                        cnt_reg     <= '0;
                        eval_reg    <= 1'b0;
                        found_reg   <= 1'b0;
                        free_reg    <= 1'b0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // read of entry cnt issued now, entry eidx evaluated now
                    eval_reg <= !last_cycle;
                    eidx_reg <= cnt_reg[IDX_W-1:0];
                    if (eval_reg) begin
                        if (match && !found_reg) begin
                            found_reg     <= 1'b1;
                            found_idx_reg <= eidx_reg;
                            found_ent_reg <= rd_entry;
                        end
                        if (!alive && !free_reg) begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= eidx_reg;
                        end
                        // strict compare keeps the lowest index on ties
                        if (eidx_reg == '0 || age > best_age_reg) begin
                            best_age_reg <= age;
                            best_idx_reg <= eidx_reg;
                        end
                    end
                    if (last_cycle) begin
                        state_reg <= (func_reg == FUNC_ADD) ? ST_WRITE : ST_RESP;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_WRITE: begin
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        unique case (func_reg)
                            FUNC_FIND_MAC, FUNC_FIND_IP: begin
                                m_hit_reg     <= found_reg;
                                m_slot_reg    <= found_reg ? SLOT_W'(found_idx_reg) : '0;
                                m_mac_reg     <= found_reg ? found_ent_reg.mac : '0;
                                m_ip_reg      <= found_reg ? found_ent_reg.ip : '0;
                                m_seen_reg    <= found_reg ? found_ent_reg.seen : '0;
                                m_evicted_reg <= 1'b0;
                            end
                            FUNC_ADD: begin
                                m_hit_reg     <= found_reg;
                                m_slot_reg    <= SLOT_W'(pick_idx);
                                m_mac_reg     <= key_mac_reg;
                                m_ip_reg      <= key_ip_reg;
                                m_seen_reg    <= now_reg;
                                m_evicted_reg <= !found_reg && !free_reg;
                            end
                            FUNC_SWEEP: begin
                                m_hit_reg     <= 1'b0;
                                m_slot_reg    <= '0;
                                m_mac_reg     <= '0;
                                m_ip_reg      <= '0;
                                m_seen_reg    <= '0;
                                m_evicted_reg <= 1'b0;
                            end
                            default: begin
                                m_hit_reg     <= 1'b0;
                                m_slot_reg    <= '0;
                                m_mac_reg     <= '0;
                                m_ip_reg      <= '0;
                                m_seen_reg    <= '0;
                                m_evicted_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_slot     = m_slot_reg;
    assign m_mac_out  = m_mac_reg;
    assign m_ip_out   = m_ip_reg;
    assign m_seen_out = m_seen_reg;
    assign m_evicted  = m_evicted_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in flight");

    a_hit_not_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("result flags both refresh and eviction");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(ENTRIES)))
        else $error("scan counter past table end");

    a_clear_on_aging: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clr_en |-> (state_reg == ST_SCAN && (func_reg == FUNC_ADD ||
                                                  func_reg == FUNC_SWEEP)))
        else $error("entry invalidated outside an aging scan");

    a_write_on_add: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wr_en |-> (func_reg == FUNC_ADD && !ctl.clr_en))
        else $error("table write outside add");

endmodule
